// ===== design/opc_pkg.sv =====
// Shared types and constants for the online Pearson correlation unit.
// No dependencies; imported by every module of the block.
package opc_pkg;

  localparam int SAMPLE_W    = 32;
  localparam int MEAN_GUARD  = 16;
  localparam int WORD_W      = 64;
  localparam int ACC_W       = 2 * WORD_W;
  localparam int OUT_FRAC    = 15;
  localparam int NUM_W       = WORD_W + OUT_FRAC;
  localparam int STEP_W      = 7;
  localparam int DIV_STEPS   = WORD_W;
  localparam int QDIV_STEPS  = NUM_W;
  localparam int SQRT_STEPS  = ACC_W / 2;

  // datapath operations
  localparam logic [3:0] OP_NONE      = 4'd0;
  localparam logic [3:0] OP_LOAD      = 4'd1;
  localparam logic [3:0] OP_MUL_STEP  = 4'd2;
  localparam logic [3:0] OP_ROUND     = 4'd3;
  localparam logic [3:0] OP_DIV_LOAD  = 4'd4;
  localparam logic [3:0] OP_DIV_STEP  = 4'd5;
  localparam logic [3:0] OP_TERM_ACC  = 4'd6;
  localparam logic [3:0] OP_MEAN_ACC  = 4'd7;
  localparam logic [3:0] OP_SQRT_LOAD = 4'd8;
  localparam logic [3:0] OP_SQRT_STEP = 4'd9;
  localparam logic [3:0] OP_QDIV_LOAD = 4'd10;
  localparam logic [3:0] OP_EMIT      = 4'd11;

  // operand selects
  localparam logic [2:0] SEL_XX  = 3'd0;
  localparam logic [2:0] SEL_YY  = 3'd1;
  localparam logic [2:0] SEL_XY  = 3'd2;
  localparam logic [2:0] SEL_MX  = 3'd3;
  localparam logic [2:0] SEL_MY  = 3'd4;
  localparam logic [2:0] SEL_FIN = 3'd5;

  // result status codes
  localparam logic [1:0] ST_VALID = 2'd0;
  localparam logic [1:0] ST_FEW   = 2'd1;
  localparam logic [1:0] ST_FLAT  = 2'd2;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_x;
    logic signed [SAMPLE_W-1:0] sample_y;
    logic                       last_sample;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] correlation;
    logic [1:0]         status;
  } out_item_t;

  typedef struct packed {
    logic [3:0] op;
    logic [2:0] sel;
    logic [1:0] pp;
  } dp_cmd_t;

  typedef struct packed {
    logic last;
    logic few;
    logic flat;
    logic out_busy;
  } dp_stat_t;

  function automatic logic [WORD_W-1:0] mag64(input logic [WORD_W-1:0] v);
    mag64 = v[WORD_W-1] ? (~v + 64'd1) : v;
  endfunction

  function automatic logic [WORD_W-1:0] sat_add64(input logic [WORD_W-1:0] a,
                                                  input logic [WORD_W-1:0] b);
    logic [WORD_W:0] s;
    s = {a[WORD_W-1], a} + {b[WORD_W-1], b};
    if (s[WORD_W] != s[WORD_W-1]) begin
      sat_add64 = s[WORD_W] ? {1'b1, {(WORD_W-1){1'b0}}} : {1'b0, {(WORD_W-1){1'b1}}};
    end else begin
      sat_add64 = s[WORD_W-1:0];
    end
  endfunction

endpackage

// ===== design/opc_ctrl.sv =====
// Sequencer for the correlation unit: steps the datapath through
// multiply, round, divide, root and emit. Depends on opc_pkg.
module opc_ctrl import opc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output dp_cmd_t  cmd,
  input  dp_stat_t stat
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MUL  = 4'd1;
  localparam logic [3:0] S_RND  = 4'd2;
  localparam logic [3:0] S_DLD  = 4'd3;
  localparam logic [3:0] S_DIV  = 4'd4;
  localparam logic [3:0] S_TACC = 4'd5;
  localparam logic [3:0] S_MACC = 4'd6;
  localparam logic [3:0] S_CHK  = 4'd7;
  localparam logic [3:0] S_SQL  = 4'd8;
  localparam logic [3:0] S_SQRT = 4'd9;
  localparam logic [3:0] S_QLD  = 4'd10;
  localparam logic [3:0] S_QDIV = 4'd11;
  localparam logic [3:0] S_EMIT = 4'd12;

  logic [3:0]        state_r, state_nxt;
  logic [2:0]        sel_r, sel_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    sel_nxt   = sel_r;
    step_nxt  = step_r;
    cmd.op    = OP_NONE;
    cmd.sel   = sel_r;
    cmd.pp    = step_r[1:0];
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          sel_nxt   = SEL_XX;
          step_nxt  = '0;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.op   = OP_MUL_STEP;
        step_nxt = step_r + STEP_W'(1);
        if (step_r[1:0] == 2'd3) begin
          step_nxt  = '0;
          state_nxt = (sel_r == SEL_FIN) ? S_SQL : S_RND;
        end
      end
      S_RND: begin
        cmd.op    = OP_ROUND;
        state_nxt = S_DLD;
      end
      S_DLD: begin
        cmd.op    = OP_DIV_LOAD;
        step_nxt  = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.op   = OP_DIV_STEP;
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(DIV_STEPS - 1)) begin
          step_nxt  = '0;
          state_nxt = (sel_r == SEL_MX || sel_r == SEL_MY) ? S_MACC : S_TACC;
        end
      end
      S_TACC: begin
        cmd.op    = OP_TERM_ACC;
        sel_nxt   = sel_r + 3'd1;
        state_nxt = (sel_r == SEL_XY) ? S_DLD : S_MUL;
      end
      S_MACC: begin
        cmd.op = OP_MEAN_ACC;
        if (sel_r == SEL_MX) begin
          sel_nxt   = SEL_MY;
          state_nxt = S_DLD;
        end else begin
          state_nxt = stat.last ? S_CHK : S_IDLE;
        end
      end
      S_CHK: begin
        if (stat.few || stat.flat) begin
          state_nxt = S_EMIT;
        end else begin
          sel_nxt   = SEL_FIN;
          step_nxt  = '0;
          state_nxt = S_MUL;
        end
      end
      S_SQL: begin
        cmd.op    = OP_SQRT_LOAD;
        step_nxt  = '0;
        state_nxt = S_SQRT;
      end
      S_SQRT: begin
        cmd.op   = OP_SQRT_STEP;
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(SQRT_STEPS - 1)) begin
          state_nxt = S_QLD;
        end
      end
      S_QLD: begin
        cmd.op    = OP_QDIV_LOAD;
        step_nxt  = '0;
        state_nxt = S_QDIV;
      end
      S_QDIV: begin
        cmd.op   = OP_DIV_STEP;
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(QDIV_STEPS - 1)) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!stat.out_busy) begin
          cmd.op    = OP_EMIT;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      sel_r   <= SEL_XX;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      sel_r   <= sel_nxt;
      step_r  <= step_nxt;
    end
  end

endmodule

// ===== design/opc_dpath.sv =====
// Datapath: running statistics, shared 32x32 multiplier, restoring
// divider, bitwise square root and output register. Depends on opc_pkg.
module opc_dpath import opc_pkg::*; #(
  parameter int COUNT_BITS = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_data,
  input  dp_cmd_t   cmd,
  output dp_stat_t  stat,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam logic [WORD_W-1:0] MAG_MAX = {1'b0, {(WORD_W-1){1'b1}}};

  logic [COUNT_BITS-1:0] cnt_r;
  logic [WORD_W-1:0]     mx_r, my_r, sxx_r, syy_r, sxy_r, dx_r, dy_r;
  logic                  last_r;
  logic [ACC_W-1:0]      acc_r;
  logic [WORD_W-1:0]     m_r;
  logic                  neg_r;
  logic [NUM_W-1:0]      num_r;
  logic [WORD_W-1:0]     den_r;
  logic [WORD_W:0]       rem_r;
  logic [WORD_W-1:0]     q_r;
  logic                  qovf_r;
  logic [WORD_W-1:0]     root_r;
  logic [WORD_W+1:0]     srem_r;
  logic                  out_valid_r;
  out_item_t             out_r;

  logic [WORD_W-1:0]     x_ext, y_ext, dx_new, dy_new, n_half, n_ext;
  logic [COUNT_BITS-1:0] cnt_inc;
  logic [WORD_W-1:0]     opa, opb;
  logic [31:0]           ha, hb;
  logic [WORD_W-1:0]     prod;
  logic [ACC_W-1:0]      pp_sh;
  logic [ACC_W-1:0]      rnd_sum;
  logic [WORD_W-1:0]     m_round;
  logic [WORD_W-1:0]     div_src;
  logic [WORD_W:0]       rsh;
  logic                  qbit;
  logic [WORD_W-1:0]     t_mag, t_val, q_sgn;
  logic [WORD_W+3:0]     s2, trial;
  logic                  rnd_up;
  logic [WORD_W:0]       qr;
  logic [15:0]           corr;
  logic [1:0]            st_code;

  always_comb begin
    x_ext   = {{(WORD_W-SAMPLE_W-MEAN_GUARD){in_data.sample_x[SAMPLE_W-1]}},
               in_data.sample_x, {MEAN_GUARD{1'b0}}};
    y_ext   = {{(WORD_W-SAMPLE_W-MEAN_GUARD){in_data.sample_y[SAMPLE_W-1]}},
               in_data.sample_y, {MEAN_GUARD{1'b0}}};
    dx_new  = x_ext - mx_r;
    dy_new  = y_ext - my_r;
    cnt_inc = (&cnt_r) ? cnt_r : cnt_r + COUNT_BITS'(1);
    n_ext   = {{(WORD_W-COUNT_BITS){1'b0}}, cnt_r};
    n_half  = n_ext >> 1;

    unique case (cmd.sel)
      SEL_XX:  begin opa = mag64(dx_r); opb = mag64(dx_r); end
      SEL_YY:  begin opa = mag64(dy_r); opb = mag64(dy_r); end
      SEL_XY:  begin opa = mag64(dx_r); opb = mag64(dy_r); end
      default: begin opa = sxx_r;       opb = syy_r;       end
    endcase
    ha   = cmd.pp[0] ? opa[WORD_W-1:32] : opa[31:0];
    hb   = cmd.pp[1] ? opb[WORD_W-1:32] : opb[31:0];
    prod = ha * hb;
    unique case (cmd.pp)
      2'd0:    pp_sh = {64'd0, prod};
      2'd3:    pp_sh = {prod, 64'd0};
      default: pp_sh = {32'd0, prod, 32'd0};
    endcase

    // round away the 2*MEAN_GUARD guard bits, saturate to the signed range
    rnd_sum = acc_r + (ACC_W'(1) << (2 * MEAN_GUARD - 1));
    if ((|rnd_sum[ACC_W-1:WORD_W+2*MEAN_GUARD]) || rnd_sum[WORD_W+2*MEAN_GUARD-1]) begin
      m_round = MAG_MAX;
    end else begin
      m_round = rnd_sum[WORD_W+2*MEAN_GUARD-1:2*MEAN_GUARD];
    end

    unique case (cmd.sel)
      SEL_MX:  div_src = mag64(dx_r);
      SEL_MY:  div_src = mag64(dy_r);
      default: div_src = m_r;
    endcase

    rsh  = {rem_r[WORD_W-1:0], num_r[NUM_W-1]};
    qbit = (rsh >= {1'b0, den_r});

    t_mag = m_r - q_r;
    t_val = neg_r ? (~t_mag + 64'd1) : t_mag;
    q_sgn = ((cmd.sel == SEL_MX) ? dx_r[WORD_W-1] : dy_r[WORD_W-1]) ? (~q_r + 64'd1) : q_r;

    s2    = {srem_r, acc_r[ACC_W-1:ACC_W-2]};
    trial = {2'b00, root_r, 2'b01};

    rnd_up = ({rem_r, 1'b0} >= {2'b00, den_r});
    qr     = {1'b0, q_r} + {{WORD_W{1'b0}}, rnd_up};
    if (!sxy_r[WORD_W-1]) begin
      corr = (qovf_r || qr > 65'd32767) ? 16'd32767 : qr[15:0];
    end else begin
      corr = (qovf_r || qr > 65'd32768) ? 16'h8000 : (~qr[15:0] + 16'd1);
    end

    stat.last     = last_r;
    stat.few      = (cnt_r < COUNT_BITS'(2));
    stat.flat     = sxx_r[WORD_W-1] || (sxx_r == '0) || syy_r[WORD_W-1] || (syy_r == '0);
    stat.out_busy = out_valid_r && out_stall;

    priority if (stat.few) begin
      st_code = ST_FEW;
    end else if (stat.flat) begin
      st_code = ST_FLAT;
    end else begin
      st_code = ST_VALID;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      mx_r  <= '0;
      my_r  <= '0;
      sxx_r <= '0;
      syy_r <= '0;
      sxy_r <= '0;
    end else begin
      unique case (cmd.op)
        OP_LOAD: begin
          dx_r   <= dx_new;
          dy_r   <= dy_new;
          cnt_r  <= cnt_inc;
          last_r <= in_data.last_sample;
        end
        OP_MUL_STEP: begin
          acc_r <= (cmd.pp == 2'd0) ? pp_sh : acc_r + pp_sh;
        end
        OP_ROUND: begin
          m_r   <= m_round;
          neg_r <= (cmd.sel == SEL_XY) && (dx_r[WORD_W-1] != dy_r[WORD_W-1]);
        end
        OP_DIV_LOAD: begin
          num_r  <= {div_src + n_half, {OUT_FRAC{1'b0}}};
          den_r  <= n_ext;
          rem_r  <= '0;
          q_r    <= '0;
          qovf_r <= 1'b0;
        end
        OP_DIV_STEP: begin
          rem_r  <= qbit ? rsh - {1'b0, den_r} : rsh;
          q_r    <= {q_r[WORD_W-2:0], qbit};
          qovf_r <= qovf_r | q_r[WORD_W-1];
          num_r  <= num_r << 1;
        end
        OP_TERM_ACC: begin
          unique case (cmd.sel)
            SEL_XX:  sxx_r <= sat_add64(sxx_r, t_val);
            SEL_YY:  syy_r <= sat_add64(syy_r, t_val);
            default: sxy_r <= sat_add64(sxy_r, t_val);
          endcase
        end
        OP_MEAN_ACC: begin
          if (cmd.sel == SEL_MX) begin
            mx_r <= mx_r + q_sgn;
          end else begin
            my_r <= my_r + q_sgn;
          end
        end
        OP_SQRT_LOAD: begin
          srem_r <= '0;
          root_r <= '0;
        end
        OP_SQRT_STEP: begin
          if (s2 >= trial) begin
            srem_r <= (WORD_W+2)'(s2 - trial);
            root_r <= {root_r[WORD_W-2:0], 1'b1};
          end else begin
            srem_r <= s2[WORD_W+1:0];
            root_r <= {root_r[WORD_W-2:0], 1'b0};
          end
          acc_r <= acc_r << 2;
        end
        OP_QDIV_LOAD: begin
          num_r  <= {mag64(sxy_r), {OUT_FRAC{1'b0}}};
          den_r  <= root_r;
          rem_r  <= '0;
          q_r    <= '0;
          qovf_r <= 1'b0;
        end
        OP_EMIT: begin
          cnt_r <= '0;
          mx_r  <= '0;
          my_r  <= '0;
          sxx_r <= '0;
          syy_r <= '0;
          sxy_r <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == OP_EMIT) begin
      out_valid_r       <= 1'b1;
      out_r.status      <= st_code;
      out_r.correlation <= (st_code == ST_VALID) ? corr : 16'd0;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== design/online_pearson_correlation_unit.sv =====
// Online Pearson correlation unit: top level joining sequencer and datapath.
// Depends on opc_pkg, opc_ctrl and opc_dpath.
//
// Input channel in_valid/in_stall/in_data carries one (x, y) pair in Q16.16
// with a flag on the final pair of a run. Each pair updates the count, the
// means and the deviation sums; a flagged pair then yields one result on
// out_valid/out_stall/out_data: the coefficient in signed Q1.15 and a status.
// Each pair runs five passes of the one-bit-per-cycle restoring divider
// and three 64x64 multiplies done as 32x32 partial products. A flagged
// pair with a valid result then takes one more multiply, a 64-step square
// root and a 79-step divide; runs that end with too few pairs or a flat
// series skip these and go straight to the result.
// in_stall is high while a pair is in progress.
// The result sits in an output register; the next pair is taken while it
// waits, and a further result waits in the sequencer until the receiver
// drops out_stall. Synchronous reset clears the run state and the output.
module online_pearson_correlation_unit import opc_pkg::*; #(
  parameter int COUNT_BITS = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  opc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .stat     (stat)
  );

  opc_dpath #(
    .COUNT_BITS (COUNT_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== design/opc_checker.sv =====
// Port-level checks for the correlation unit, bound to the top level.
// Depends on opc_pkg and online_pearson_correlation_unit.
module opc_checker import opc_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // a result never survives reset
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result present after reset");

  // a pair keeps the unit busy for the following cycle at least
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("pair taken without busy period");

  // a stalled input transaction is held by the sender
  a_in_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_stall) |=> (in_valid && $stable(in_data)))
    else $error("stalled pair changed");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("stalled result dropped");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> $stable(out_data))
    else $error("stalled result changed");

endmodule

bind online_pearson_correlation_unit opc_checker u_opc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
